@@ hw/rtl/ucte_pkg.sv @@
// Shared constants and helpers for the UTF-8 CJK token estimator.
// Holds byte class tags, CJK code point ranges and the range check.
// No dependencies; imported by every module of the block.
package ucte_pkg;

  // counter width and threshold register
  localparam int COUNT_BITS_DEF = 32;
  localparam int THR_BITS       = 17;
  localparam logic [THR_BITS-1:0] THR_RESET = 17'd32768;

  // byte class tags, compared against the top bits of a byte
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // open sequence lengths
  localparam logic [1:0] EXPECT_NONE = 2'd0;
  localparam logic [1:0] EXPECT_ONE  = 2'd1;
  localparam logic [1:0] EXPECT_TWO  = 2'd2;
  localparam logic [1:0] EXPECT_THREE = 2'd3;

  // cjk code point ranges
  localparam logic [20:0] HIRA_LO   = 21'h03040;
  localparam logic [20:0] KATA_HI   = 21'h030FF;
  localparam logic [20:0] EXTA_LO   = 21'h03400;
  localparam logic [20:0] EXTA_HI   = 21'h04DBF;
  localparam logic [20:0] UNI_LO    = 21'h04E00;
  localparam logic [20:0] UNI_HI    = 21'h09FFF;
  localparam logic [20:0] HANGUL_LO = 21'h0AC00;
  localparam logic [20:0] HANGUL_HI = 21'h0D7AF;
  localparam logic [20:0] FULLW_LO  = 21'h0FF00;
  localparam logic [20:0] FULLW_HI  = 21'h0FFEF;
  localparam logic [20:0] EXTB_LO   = 21'h20000;
  localparam logic [20:0] EXTB_HI   = 21'h2EBEF;

  // ratio tests, reduced: ascii*20 > total*19, cjk*20 > total*3
  localparam int RATIO_SHIFT = 16;

  // hiragana and katakana are adjacent, so they form one range
  function automatic logic in_cjk(input logic [20:0] cp);
    logic hit;
    hit = ((cp >= HIRA_LO)   && (cp <= KATA_HI))
       || ((cp >= EXTA_LO)   && (cp <= EXTA_HI))
       || ((cp >= UNI_LO)    && (cp <= UNI_HI))
       || ((cp >= HANGUL_LO) && (cp <= HANGUL_HI))
       || ((cp >= FULLW_LO)  && (cp <= FULLW_HI))
       || ((cp >= EXTB_LO)   && (cp <= EXTB_HI));
    return hit;
  endfunction

endpackage

@@ hw/rtl/ucte_decoder.sv @@
// Byte-wise UTF-8 decoder with saturating message counters.
// Hands the flushed counts of each message to the ratio pipeline.
// Depends on ucte_pkg.
module ucte_decoder import ucte_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  has_byte,
  input  logic                  last,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [COUNT_BITS-1:0] res_total,
  output logic [COUNT_BITS-1:0] res_ascii,
  output logic [COUNT_BITS-1:0] res_cjk
);

  logic [1:0]            expect_remaining, expect_remaining_next;
  logic [2:0]            seq_length, seq_length_next;
  logic [20:0]           partial_code_point, partial_code_point_next;
  logic [COUNT_BITS-1:0] total_counter, ascii_counter, cjk_counter;
  logic [COUNT_BITS-1:0] total_next, ascii_next, cjk_next;

  logic        accept;
  logic        is_cont, take_cont, brk, start, complete;
  logic        single, ascii_hit, cjk_hit;
  logic [20:0] cp_join;
  logic [2:0]  flush_inc, last_flush, total_inc;
  logic [COUNT_BITS:0] total_sum, ascii_sum, cjk_sum;

  assign in_ready = !res_valid || res_ready;
  assign accept   = in_valid && in_ready;

  // decode one byte against the open sequence
  always_comb begin
    is_cont   = (data_byte[7:6] == CONT_TAG);
    take_cont = has_byte && (expect_remaining != EXPECT_NONE) && is_cont;
    brk       = has_byte && (expect_remaining != EXPECT_NONE) && !is_cont;
    start     = has_byte && !take_cont;
    complete  = take_cont && (expect_remaining == EXPECT_ONE);
    cp_join   = {partial_code_point[14:0], data_byte[5:0]};
    cjk_hit   = complete && in_cjk(cp_join);

    expect_remaining_next   = expect_remaining;
    seq_length_next         = seq_length;
    partial_code_point_next = partial_code_point;
    single                  = 1'b0;
    ascii_hit               = 1'b0;

    if (take_cont) begin
      if (complete) begin
        expect_remaining_next   = EXPECT_NONE;
        seq_length_next         = 3'd0;
        partial_code_point_next = 21'd0;
      end else begin
        expect_remaining_next   = expect_remaining - 2'd1;
        seq_length_next         = seq_length + 3'd1;
        partial_code_point_next = cp_join;
      end
    end else if (start) begin
      // the state is cleared before the arms, so a broken sequence is dropped here
      expect_remaining_next   = EXPECT_NONE;
      seq_length_next         = 3'd0;
      partial_code_point_next = 21'd0;
      if (!data_byte[7]) begin
        single    = 1'b1;
        ascii_hit = 1'b1;
      end else if (data_byte[7:5] == LEAD2_TAG) begin
        expect_remaining_next   = EXPECT_ONE;
        seq_length_next         = 3'd1;
        partial_code_point_next = 21'(data_byte[4:0]);
      end else if (data_byte[7:4] == LEAD3_TAG) begin
        expect_remaining_next   = EXPECT_TWO;
        seq_length_next         = 3'd1;
        partial_code_point_next = 21'(data_byte[3:0]);
      end else if (data_byte[7:3] == LEAD4_TAG) begin
        expect_remaining_next   = EXPECT_THREE;
        seq_length_next         = 3'd1;
        partial_code_point_next = 21'(data_byte[2:0]);
      end else begin
        single = 1'b1;
      end
    end

    // broken sequence bytes and a sequence left open at the end count singly
    flush_inc  = brk ? seq_length : 3'd0;
    last_flush = last ? seq_length_next : 3'd0;
    total_inc  = flush_inc + 3'(single) + 3'(complete) + last_flush;
  end

  // saturating counter updates
  always_comb begin
    total_sum = {1'b0, total_counter} + (COUNT_BITS+1)'(total_inc);
    ascii_sum = {1'b0, ascii_counter} + (COUNT_BITS+1)'(ascii_hit);
    cjk_sum   = {1'b0, cjk_counter} + (COUNT_BITS+1)'(cjk_hit);
    total_next = total_sum[COUNT_BITS] ? '1 : total_sum[COUNT_BITS-1:0];
    ascii_next = ascii_sum[COUNT_BITS] ? '1 : ascii_sum[COUNT_BITS-1:0];
    cjk_next   = cjk_sum[COUNT_BITS] ? '1 : cjk_sum[COUNT_BITS-1:0];
  end

  // decoder state, counters and handoff valid
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_remaining   <= EXPECT_NONE;
      seq_length         <= 3'd0;
      partial_code_point <= 21'd0;
      total_counter      <= '0;
      ascii_counter      <= '0;
      cjk_counter        <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (accept && last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        if (last) begin
          expect_remaining   <= EXPECT_NONE;
          seq_length         <= 3'd0;
          partial_code_point <= 21'd0;
          total_counter      <= '0;
          ascii_counter      <= '0;
          cjk_counter        <= '0;
        end else begin
          expect_remaining   <= expect_remaining_next;
          seq_length         <= seq_length_next;
          partial_code_point <= partial_code_point_next;
          total_counter      <= total_next;
          ascii_counter      <= ascii_next;
          cjk_counter        <= cjk_next;
        end
      end
    end
  end

  // final counts of a message
  always_ff @(posedge clk) begin
    if (accept && last) begin
      res_total <= total_next;
      res_ascii <= ascii_next;
      res_cjk   <= cjk_next;
    end
  end

endmodule

@@ hw/rtl/ucte_ratio.sv @@
// Ratio tests and token estimate pipeline for finished messages.
// Four register stages: products, compares and divide by 3, divide by 7, result.
// Depends on ucte_pkg.
module ucte_ratio import ucte_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [THR_BITS-1:0]   threshold,
  input  logic                  res_valid,
  output logic                  res_ready,
  input  logic [COUNT_BITS-1:0] res_total,
  input  logic [COUNT_BITS-1:0] res_ascii,
  input  logic [COUNT_BITS-1:0] res_cjk,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           code_point_count,
  output logic [31:0]           ascii_count,
  output logic [31:0]           cjk_points,
  output logic                  mostly_cjk,
  output logic [30:0]           token_estimate
);

  localparam int N   = COUNT_BITS;
  localparam int PW  = N + THR_BITS;
  localparam int PW2 = 2 * N + 1;
  // reciprocals exact for any N-bit dividend
  localparam longint unsigned M3_FULL = ((64'd1 << (N + 2)) + 64'd2) / 64'd3;
  localparam longint unsigned M7_FULL = ((64'd1 << (N + 3)) + 64'd6) / 64'd7;
  localparam logic [N:0] M3 = M3_FULL[N:0];
  localparam logic [N:0] M7 = M7_FULL[N:0];

  logic acc_b, acc_c, acc_d, acc_o;

  // stage b: threshold product and scaled counts
  logic            b_valid;
  logic [N-1:0]    b_t, b_a, b_c;
  logic [PW-1:0]   b_thr_prod;
  logic [N+4:0]    b_a20, b_t19, b_c20;
  logic [N+1:0]    b_t3;

  // stage c: compares and divide by 3
  logic            c_valid;
  logic [N-1:0]    c_t, c_a, c_c;
  logic            c_flag, c_sel_a, c_sel_c;
  logic [N-2:0]    c_q3;
  logic [PW-1:0]   cjk_shift;
  logic [PW2-1:0]  prod3;

  // stage d: divide by 7
  logic            d_valid;
  logic [N-1:0]    d_t, d_a, d_c;
  logic            d_flag, d_sel_a, d_sel_c;
  logic [N-2:0]    d_q3;
  logic [N-3:0]    d_q7;
  logic [PW2-1:0]  prod7;

  // result selection
  logic [2:0]      rem7;
  logic [N-2:0]    est7, est_sel, est;

  // a stage takes new data when empty or when its contents move on
  assign acc_o     = !out_valid || out_ready;
  assign acc_d     = !d_valid || acc_o;
  assign acc_c     = !c_valid || acc_d;
  assign acc_b     = !b_valid || acc_c;
  assign res_ready = acc_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc_b) begin
        b_valid <= res_valid;
      end
      if (acc_c) begin
        c_valid <= b_valid;
      end
      if (acc_d) begin
        d_valid <= c_valid;
      end
      if (acc_o) begin
        out_valid <= d_valid;
      end
    end
  end

  // stage b
  always_ff @(posedge clk) begin
    if (acc_b) begin
      b_t        <= res_total;
      b_a        <= res_ascii;
      b_c        <= res_cjk;
      b_thr_prod <= PW'(threshold) * PW'(res_total);
      b_a20      <= (N+5)'({res_ascii, 4'b0}) + (N+5)'({res_ascii, 2'b0});
      b_t19      <= (N+5)'({res_total, 4'b0}) + (N+5)'({res_total, 1'b0})
                  + (N+5)'(res_total);
      b_c20      <= (N+5)'({res_cjk, 4'b0}) + (N+5)'({res_cjk, 2'b0});
      b_t3       <= (N+2)'({res_total, 1'b0}) + (N+2)'(res_total);
    end
  end

  // stage c
  assign cjk_shift = PW'({b_c, RATIO_SHIFT'(0)});
  assign prod3     = PW2'(b_t) * PW2'(M3);

  always_ff @(posedge clk) begin
    if (acc_c) begin
      c_t     <= b_t;
      c_a     <= b_a;
      c_c     <= b_c;
      c_flag  <= (b_t != '0) && (cjk_shift > b_thr_prod);
      c_sel_a <= b_a20 > b_t19;
      c_sel_c <= b_c20 > (N+5)'(b_t3);
      c_q3    <= prod3[2*N:N+2];
    end
  end

  // stage d
  assign prod7 = PW2'(c_t) * PW2'(M7);

  always_ff @(posedge clk) begin
    if (acc_d) begin
      d_t     <= c_t;
      d_a     <= c_a;
      d_c     <= c_c;
      d_flag  <= c_flag;
      d_sel_a <= c_sel_a;
      d_sel_c <= c_sel_c;
      d_q3    <= c_q3;
      d_q7    <= prod7[2*N:N+3];
    end
  end

  // floor(2t/7) = 2q + (r >= 4), where r = t - 7q needs only its low bits
  always_comb begin
    rem7    = d_t[2:0] + d_q7[2:0];
    est7    = (N-1)'({d_q7, 1'b0}) + (N-1)'(rem7[2]);
    if (d_sel_a) begin
      est_sel = (N-1)'(d_t[N-1:2]);
    end else if (d_sel_c) begin
      est_sel = d_q3;
    end else begin
      est_sel = est7;
    end
    // empty message gives zero, otherwise at least one
    if (d_t == '0) begin
      est = '0;
    end else if (est_sel == '0) begin
      est = (N-1)'(1);
    end else begin
      est = est_sel;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (acc_o) begin
      code_point_count <= 32'(d_t);
      ascii_count      <= 32'(d_a);
      cjk_points       <= 32'(d_c);
      mostly_cjk       <= d_flag;
      token_estimate   <= 31'(est);
    end
  end

endmodule

@@ hw/rtl/utf8_cjk_token_estimator.sv @@
// Top level of the UTF-8 CJK token estimator.
// Instantiates ucte_decoder and ucte_ratio; depends on ucte_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per message byte, with
//   has_byte = 0 for an item that carries no byte and last = 1 on the final
//   request of a message. One request is taken every clock cycle while
//   in_ready is high; the decoder updates its counters in the cycle a
//   byte is taken. Output channel (out_valid/out_ready): one request per
//   message, giving the counts, the CJK flag and the token estimate.
//   out_valid rises after the result passes the decoder's result register,
//   ratio stage b (threshold product), stage c (compares and divide by 3),
//   stage d (divide by 7) and the ratio result register.
//   Throughput is one input request per cycle while in_ready is high, set
//   by the decoder's update; up to five finished messages can be in flight.
//   When the receiver stalls, finished messages fill the pipeline stages;
//   in_ready drops only once all of them hold a waiting result.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data): always ready;
//   write the threshold only while no message is in flight.
//   Reset clears the decoder state, counters and pipeline, and sets the
//   threshold to one half.
module utf8_cjk_token_estimator import ucte_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [THR_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                has_byte,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         code_point_count,
  output logic [31:0]         ascii_count,
  output logic [31:0]         cjk_points,
  output logic                mostly_cjk,
  output logic [30:0]         token_estimate
);

  logic [THR_BITS-1:0]   cjk_threshold;
  logic                  res_valid, res_ready;
  logic [COUNT_BITS-1:0] res_total, res_ascii, res_cjk;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cjk_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cjk_threshold <= cfg_data;
    end
  end

  // byte decode and counting
  ucte_decoder #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_total (res_total),
    .res_ascii (res_ascii),
    .res_cjk   (res_cjk)
  );

  // ratio tests and estimate
  ucte_ratio #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ratio (
    .clk              (clk),
    .rst              (rst),
    .threshold        (cjk_threshold),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res_total        (res_total),
    .res_ascii        (res_ascii),
    .res_cjk          (res_cjk),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .code_point_count (code_point_count),
    .ascii_count      (ascii_count),
    .cjk_points       (cjk_points),
    .mostly_cjk       (mostly_cjk),
    .token_estimate   (token_estimate)
  );

endmodule

@@ dv/ucte_tb_pkg.sv @@
// Scoreboard for the UTF-8 CJK token estimator testbench: a cycle-free predictor
// of the per-message counts, flag and token estimate, plus the expected-result queue.
// Depends on ucte_pkg for the threshold width, continuation tag and sequence lengths.
`timescale 1ns / 100ps

package ucte_tb_pkg;

  import ucte_pkg::THR_BITS;
  import ucte_pkg::CONT_TAG;
  import ucte_pkg::EXPECT_NONE;
  import ucte_pkg::EXPECT_ONE;
  import ucte_pkg::EXPECT_TWO;
  import ucte_pkg::EXPECT_THREE;

  localparam logic [THR_BITS-1:0] THR_AT_RESET = 17'd32768;
  localparam logic [31:0]         COUNT_LIMIT  = 32'hFFFF_FFFF;

  // cjk ranges: hiragana, katakana, ext a, unified, hangul, fullwidth, ext b
  localparam int N_CJK_RANGES = 7;
  localparam logic [20:0] CJK_LO [N_CJK_RANGES] = '{
    21'h03040, 21'h030A0, 21'h03400, 21'h04E00, 21'h0AC00, 21'h0FF00, 21'h20000};
  localparam logic [20:0] CJK_HI [N_CJK_RANGES] = '{
    21'h0309F, 21'h030FF, 21'h04DBF, 21'h09FFF, 21'h0D7AF, 21'h0FFEF, 21'h2EBEF};

  typedef struct packed {
    logic [31:0] cp_count;
    logic [31:0] ascii;
    logic [31:0] cjk;
    logic        flag;
    logic [30:0] estimate;
  } msg_summary_t;

  class token_scoreboard;
    msg_summary_t        expected_q[$];
    logic [THR_BITS-1:0] threshold;
    logic [1:0]          cont_left;
    logic [2:0]          seq_bytes;
    logic [20:0]         cp_acc;
    logic [31:0]         n_total;
    logic [31:0]         n_ascii;
    logic [31:0]         n_cjk;
    int unsigned         n_checked;
    int unsigned         n_errors;

    function new();
      threshold = THR_AT_RESET;
      n_checked = 0;
      n_errors  = 0;
      clear_message();
    endfunction

    function void clear_message();
      cont_left = EXPECT_NONE;
      seq_bytes = 3'd0;
      cp_acc    = 21'd0;
      n_total   = 32'd0;
      n_ascii   = 32'd0;
      n_cjk     = 32'd0;
    endfunction

    function void set_threshold(input logic [THR_BITS-1:0] value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // counters stop at all ones
    function logic [31:0] sat_add(input logic [31:0] v, input int unsigned n);
      logic [32:0] s;
      s = {1'b0, v} + 33'(n);
      return s[32] ? COUNT_LIMIT : s[31:0];
    endfunction

    // an open sequence that ends early counts each buffered byte once
    function void close_sequence();
      if (seq_bytes != 3'd0) n_total = sat_add(n_total, seq_bytes);
      seq_bytes = 3'd0;
      cont_left = EXPECT_NONE;
      cp_acc    = 21'd0;
    endfunction

    function void take_byte(input logic [7:0] b);
      logic hit;
      // continuation byte inside an open sequence
      if (cont_left != EXPECT_NONE) begin
        if (b[7:6] == CONT_TAG) begin
          cp_acc    = {cp_acc[14:0], b[5:0]};
          seq_bytes = seq_bytes + 3'd1;
          cont_left = cont_left - 2'd1;
          if (cont_left == EXPECT_NONE) begin
            hit = 1'b0;
            for (int r = 0; r < N_CJK_RANGES; r++) begin
              if (cp_acc >= CJK_LO[r] && cp_acc <= CJK_HI[r]) hit = 1'b1;
            end
            n_total = sat_add(n_total, 1);
            if (hit) n_cjk = sat_add(n_cjk, 1);
            seq_bytes = 3'd0;
            cp_acc    = 21'd0;
          end
          return;
        end
        close_sequence();
      end
      // fresh byte: ascii, lead byte, or stray
      if (b < 8'h80) begin
        n_total = sat_add(n_total, 1);
        n_ascii = sat_add(n_ascii, 1);
      end else if (b >= 8'hC0 && b <= 8'hDF) begin
        cont_left = EXPECT_ONE;
        seq_bytes = 3'd1;
        cp_acc    = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        cont_left = EXPECT_TWO;
        seq_bytes = 3'd1;
        cp_acc    = {17'd0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF7) begin
        cont_left = EXPECT_THREE;
        seq_bytes = 3'd1;
        cp_acc    = {18'd0, b[2:0]};
      end else begin
        n_total = sat_add(n_total, 1);
      end
    endfunction

    // accepted input request; the last one of a message queues a summary
    function void note_request(input logic [7:0] b, input logic has, input logic fin);
      logic [63:0]  t;
      logic [63:0]  a;
      logic [63:0]  c;
      logic [63:0]  e;
      msg_summary_t s;
      if (has) take_byte(b);
      if (!fin) return;
      close_sequence();
      t = 64'(n_total);
      a = 64'(n_ascii);
      c = 64'(n_cjk);
      // exact cross-multiplied ratio tests
      s.flag = (t != 64'd0) && (c * 64'd65536 > 64'(threshold) * t);
      if (t == 64'd0) begin
        e = 64'd0;
      end else begin
        if (a * 64'd100 > t * 64'd95) e = t / 64'd4;
        else if (c * 64'd100 > t * 64'd15) e = t / 64'd3;
        else e = (t * 64'd2) / 64'd7;
        if (e < 64'd1) e = 64'd1;
      end
      s.cp_count = n_total;
      s.ascii    = n_ascii;
      s.cjk      = n_cjk;
      s.estimate = e[30:0];
      expected_q.push_back(s);
      clear_message();
    endfunction

    // accepted result request, compared against the oldest summary
    function void check_result(input msg_summary_t got);
      msg_summary_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("error: result with no message pending: cp=%0d ascii=%0d cjk=%0d",
                   got.cp_count, got.ascii, got.cjk);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.cp_count !== want.cp_count || got.ascii !== want.ascii ||
          got.cjk !== want.cjk || got.flag !== want.flag ||
          got.estimate !== want.estimate) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("mismatch on message %0d:", n_checked);
          $display("  want cp=%0d ascii=%0d cjk=%0d flag=%0b est=%0d",
                   want.cp_count, want.ascii, want.cjk, want.flag, want.estimate);
          $display("  got  cp=%0d ascii=%0d cjk=%0d flag=%0b est=%0d",
                   got.cp_count, got.ascii, got.cjk, got.flag, got.estimate);
        end
      end
    endfunction
  endclass

endpackage

@@ dv/tb.sv @@
// Top-level testbench for utf8_cjk_token_estimator: directed and random UTF-8
// messages under sender and receiver backpressure, several threshold settings.
// Depends on ucte_pkg and ucte_tb_pkg (scoreboard and predictor).
`timescale 1ns / 100ps

module tb import ucte_pkg::*, ucte_tb_pkg::*;;

  localparam int          N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 180;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          END_CYCLES      = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  typedef enum int unsigned {
    MSG_CJK, MSG_ASCII, MSG_MIXED, MSG_BROKEN, MSG_NOISE
  } msg_kind_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [THR_BITS-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          data_byte = 8'd0;
  logic                has_byte = 1'b0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [31:0]         code_point_count;
  logic [31:0]         ascii_count;
  logic [31:0]         cjk_points;
  logic                mostly_cjk;
  logic [30:0]         token_estimate;

  token_scoreboard sb;
  logic [7:0]      msg_q[$];
  int unsigned     items_sent = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     idle_cycles = 0;

  utf8_cjk_token_estimator i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .has_byte         (has_byte),
    .last             (last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .code_point_count (code_point_count),
    .ascii_count      (ascii_count),
    .cjk_points       (cjk_points),
    .mostly_cjk       (mostly_cjk),
    .token_estimate   (token_estimate)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready)
        sb.check_result({code_point_count, ascii_count, cjk_points, mostly_cjk,
                         token_estimate});
    end
  end

  // watchdog: too long without any request moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one input request, with a random gap in front of it
  task automatic send_item(input logic [7:0] b, input logic hb, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= hb;
    last      <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b, hb, fin);
    if (hb || fin) items_sent++;
  endtask

  // hold off the sender until every pending result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_threshold(value);
  endtask

  // bytes of msg_q, with now and then an ignored idle request in between
  task automatic send_message(input logic end_only);
    logic close_alone;
    close_alone = end_only || (msg_q.size() == 0);
    for (int i = 0; i < msg_q.size(); i++) begin
      if ($urandom_range(29) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(msg_q[i], 1'b1, !close_alone && (i == msg_q.size() - 1));
    end
    if (close_alone) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // utf-8 encoding, shortest form except for an occasional overlong one
  task automatic push_code_point(input logic [20:0] cp);
    int unsigned len;
    if (cp < 21'h80) len = 1;
    else if (cp < 21'h800) len = 2;
    else if (cp < 21'h10000) len = 3;
    else len = 4;
    if ($urandom_range(19) == 0) len = $urandom_range(4, len);
    case (len)
      1: msg_q.push_back({1'b0, cp[6:0]});
      2: begin
        msg_q.push_back({LEAD2_TAG, cp[10:6]});
        msg_q.push_back({CONT_TAG, cp[5:0]});
      end
      3: begin
        msg_q.push_back({LEAD3_TAG, cp[15:12]});
        msg_q.push_back({CONT_TAG, cp[11:6]});
        msg_q.push_back({CONT_TAG, cp[5:0]});
      end
      default: begin
        msg_q.push_back({LEAD4_TAG, cp[20:18]});
        msg_q.push_back({CONT_TAG, cp[17:12]});
        msg_q.push_back({CONT_TAG, cp[11:6]});
        msg_q.push_back({CONT_TAG, cp[5:0]});
      end
    endcase
  endtask

  // code point from a cjk range, often right on or just past an edge
  function automatic logic [20:0] cjk_cp();
    int unsigned r;
    r = $urandom_range(N_CJK_RANGES - 1);
    case ($urandom_range(4))
      0:       return CJK_LO[r] - 21'd1;
      1:       return CJK_LO[r];
      2:       return CJK_HI[r];
      3:       return CJK_HI[r] + 21'd1;
      default: return 21'($urandom_range(CJK_HI[r], CJK_LO[r]));
    endcase
  endfunction

  // text character: cjk, any code point (small ones favored) or ascii
  function automatic logic [20:0] text_cp(input int unsigned cjk_pct,
                                           input int unsigned other_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < cjk_pct) return cjk_cp();
    if (r < cjk_pct + other_pct) return 21'($urandom) >> $urandom_range(20);
    return 21'($urandom_range(8'h7F));
  endfunction

  task automatic build_message();
    msg_kind_t   kind;
    int unsigned r;
    int unsigned n;
    int unsigned pos;
    msg_q.delete();
    r = $urandom_range(99);
    if (r < 35) kind = MSG_CJK;
    else if (r < 60) kind = MSG_ASCII;
    else if (r < 78) kind = MSG_MIXED;
    else if (r < 90) kind = MSG_BROKEN;
    else kind = MSG_NOISE;
    case (kind)
      MSG_CJK: begin
        n = $urandom_range(1, 8);
        repeat (n) push_code_point(text_cp(70, 10));
      end
      MSG_ASCII: begin
        n = $urandom_range(1, 40);
        repeat (n) push_code_point(text_cp(2, 2));
      end
      MSG_MIXED: begin
        n = $urandom_range(1, 8);
        repeat (n) push_code_point(text_cp(20, 60));
      end
      MSG_BROKEN: begin
        // well-formed text with one byte dropped, inserted or cut off the end
        n = $urandom_range(1, 6);
        repeat (n) push_code_point(text_cp(50, 20));
        pos = $urandom_range(msg_q.size() - 1);
        case ($urandom_range(2))
          0:       msg_q.delete(pos);
          1:       msg_q.insert(pos, 8'($urandom_range(255)));
          default: msg_q.delete(msg_q.size() - 1);
        endcase
      end
      default: begin
        n = $urandom_range(0, 10);
        repeat (n) msg_q.push_back(8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned goal;
    int unsigned n_msgs;
    goal   = items_sent + n_items;
    n_msgs = 0;
    while (items_sent < goal) begin
      build_message();
      send_message($urandom_range(7) == 0);
      n_msgs++;
      // now and then let the pipeline run completely dry
      if (n_msgs % 25 == 12) wait_drain();
    end
  endtask

  initial begin
    logic [THR_BITS-1:0] thr_plan [N_PHASES];
    int unsigned         send_plan [4];
    int unsigned         recv_plan [4];
    thr_plan  = '{17'd0, 17'd65536, 17'd1, 17'd131071, 17'd65535, 17'd19661, 17'd32768,
                  17'd0};
    thr_plan[N_PHASES-1] = 17'($urandom_range(131071));
    send_plan = '{0, 50, 0, 23};
    recv_plan = '{0, 0, 50, 23};
    sb = new();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset threshold
    send_item(8'h00, 1'b0, 1'b1);                          // empty message
    send_item(8'hA5, 1'b0, 1'b0);                          // idle request, no effect
    msg_q = '{8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF};          // ascii extremes and strays
    send_message(1'b0);
    msg_q = '{8'hE4, 8'hB8, 8'h80};                        // first unified ideograph
    send_message(1'b0);
    msg_q = '{8'hF0, 8'hA0, 8'h80, 8'h80, 8'hC3, 8'hA9};   // ext b start, latin two-byte
    send_message(1'b0);
    msg_q = '{8'hEF, 8'hBF, 8'hAF, 8'hEF, 8'hBF, 8'hB0};   // fullwidth top and one past
    send_message(1'b0);
    msg_q = '{8'hE4, 8'h41};                               // sequence broken by ascii
    send_message(1'b0);
    msg_q = '{8'hF0, 8'hA0};                               // truncated after its second byte
    send_message(1'b0);
    msg_q = '{8'hE4, 8'hB8};                               // open sequence, end-only close
    send_message(1'b1);

    // random phases, threshold written only with nothing in flight
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_threshold(thr_plan[p]);
      send_idle_pct  = send_plan[p % 4];
      recv_stall_pct = recv_plan[p % 4];
      run_phase(ITEMS_PER_PHASE);
    end

    // drain, then watch for stray results
    recv_stall_pct = 0;
    wait_drain();
    repeat (END_CYCLES) @(posedge clk);

    $display("run covered %0d byte and end requests, %0d messages checked,",
             items_sent, sb.n_checked);
    $display("%0d threshold settings including 0, 65536 and 131071, %0d mismatches",
             N_PHASES + 1, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
